[rtl/trdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdd_pkg
// Shared types, constants and the seven-segment decoder for the temperature
// reading to display digits block.
// ----------------------------------------------------------------------------
package trdd_pkg;

    // Widths of the data path.
    localparam int RAW_W    = 16;
    localparam int TENTHS_W = 15;   // tenths of a degree, at most 20480
    localparam int SHOWN_W  = 14;   // saturated tenths, at most 9999
    localparam int DEG_W    = 12;   // whole-degree magnitude, at most 2048
    localparam int SDEG_W   = 13;   // signed whole degrees
    localparam int PAIR_W   = 7;    // two-digit group, 0 to 99
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 8;
    localparam int LIMIT_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Saturation limit of the displayed value.
    localparam logic [TENTHS_W-1:0] TENTHS_MAX = 15'd9999;

    // Reciprocal multipliers for division by constants.
    // 52429 / 2^19 is one tenth, exact for values below 20481.
    localparam logic [15:0] RECIP_10_WIDE = 16'd52429;
    localparam int          RECIP_10_WIDE_SH = 19;
    // 5243 / 2^19 is one hundredth, exact for values below 10000.
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_100_SH  = 19;
    // 205 / 2^11 is one tenth, exact for values below 100.
    localparam logic [7:0]  RECIP_10_NARROW = 8'd205;
    localparam int          RECIP_10_NARROW_SH = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ALARM       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ALARM        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CATHODE_POLARITY = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] HIGH_ALARM_RST = 8'd20;
    localparam logic [LIMIT_W-1:0] LOW_ALARM_RST  = 8'd13;

    // Status flags that travel alongside the digits.
    typedef struct packed {
        logic is_negative;
        logic overflow;
        logic alarm;
    } trdd_flags_t;

    // Four decimal digits of the shown value.
    typedef struct packed {
        logic [DIGIT_W-1:0] thousands;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } trdd_digits_t;

    // Seven-segment code of one digit; common-cathode codes are the inverse
    // of the common-anode codes.
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit,
                                                  input logic cathode);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hFF;
        endcase
        return cathode ? ~code : code;
    endfunction

endpackage

[rtl/trdd_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdd_digits
// Two-stage pipeline that splits a value from 0 to 9999 into four decimal
// digits by reciprocal multiplication.
// ----------------------------------------------------------------------------
module trdd_digits
    import trdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [SHOWN_W-1:0] shown,
    output logic               out_valid,
    output trdd_digits_t       digits
);

    // Stage A: split into the upper and lower pairs of digits.
    logic                    valid_a_reg;
    logic [PAIR_W-1:0]       hi_pair_reg, hi_pair_next;
    logic [PAIR_W-1:0]       lo_pair_reg, lo_pair_next;
    logic [SHOWN_W+12:0]     hundred_prod;
    logic [SHOWN_W-1:0]      hundreds_back;
    logic [SHOWN_W-1:0]      lo_wide;

    always_comb
    begin
        hundred_prod  = (SHOWN_W+13)'(shown) * (SHOWN_W+13)'(RECIP_100);
        hi_pair_next  = hundred_prod[RECIP_100_SH +: PAIR_W];
        // Multiply by 100 as 64 + 32 + 4.
        hundreds_back = (SHOWN_W)'({hi_pair_next, 6'b0})
                      + (SHOWN_W)'({hi_pair_next, 5'b0})
                      + (SHOWN_W)'({hi_pair_next, 2'b0});
        lo_wide       = shown - hundreds_back;
        lo_pair_next  = lo_wide[PAIR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_pair_reg <= hi_pair_next;
        lo_pair_reg <= lo_pair_next;
    end

    // Stage B: split each pair into its tens and ones digit.
    logic                  valid_b_reg;
    trdd_digits_t          digits_reg, digits_next;
    logic [PAIR_W+7:0]     hi_prod, lo_prod;
    logic [DIGIT_W-1:0]    hi_tens, lo_tens;
    logic [PAIR_W-1:0]     hi_back, lo_back;
    logic [PAIR_W-1:0]     hi_rem, lo_rem;

    always_comb
    begin
        hi_prod = (PAIR_W+8)'(hi_pair_reg) * (PAIR_W+8)'(RECIP_10_NARROW);
        lo_prod = (PAIR_W+8)'(lo_pair_reg) * (PAIR_W+8)'(RECIP_10_NARROW);
        hi_tens = hi_prod[RECIP_10_NARROW_SH +: DIGIT_W];
        lo_tens = lo_prod[RECIP_10_NARROW_SH +: DIGIT_W];
        // Multiply by 10 as 8 + 2.
        hi_back = (PAIR_W)'({hi_tens, 3'b0}) + (PAIR_W)'({hi_tens, 1'b0});
        lo_back = (PAIR_W)'({lo_tens, 3'b0}) + (PAIR_W)'({lo_tens, 1'b0});
        hi_rem  = hi_pair_reg - hi_back;
        lo_rem  = lo_pair_reg - lo_back;
        digits_next.thousands = hi_tens;
        digits_next.hundreds  = hi_rem[DIGIT_W-1:0];
        digits_next.tens      = lo_tens;
        digits_next.ones      = lo_rem[DIGIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

    assign out_valid = valid_b_reg;
    assign digits    = digits_reg;

endmodule

[rtl/temp_reading_to_display_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_reading_to_display_digits
// Converts a raw two's-complement temperature word in 1/16 degree steps into
// four decimal digits of tenths, seven-segment codes, and alarm and overflow
// flags.
//
//   Channel   Handshake              Beat
//   input     start, busy            raw_reading
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data
//   result    result_valid           is_negative, digits, segments, alarm,
//                                    overflow
//
// A reading is taken in every cycle; busy stays low.
// Each result appears as a one-cycle strobe after its reading has passed the
// five register stages: scaling, division by ten and saturation, the hundreds
// split, the tens split, and segment decoding.
// Reset clears the stage valid bits and loads the register reset values.
// The receiver cannot stall, so no stall logic exists.
// ----------------------------------------------------------------------------
module temp_reading_to_display_digits
    import trdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [RAW_W-1:0]     raw_reading,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    output logic                 result_valid,
    output logic                 is_negative,
    output logic [DIGIT_W-1:0]   digit_thousands,
    output logic [DIGIT_W-1:0]   digit_hundreds,
    output logic [DIGIT_W-1:0]   digit_tens,
    output logic [DIGIT_W-1:0]   digit_ones,
    output logic [SEG_W-1:0]     segments_thousands,
    output logic [SEG_W-1:0]     segments_hundreds,
    output logic [SEG_W-1:0]     segments_tens,
    output logic [SEG_W-1:0]     segments_ones,
    output logic                 alarm,
    output logic                 overflow
);

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    logic [LIMIT_W-1:0] high_alarm_reg;
    logic [LIMIT_W-1:0] low_alarm_reg;
    logic               cathode_polarity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_alarm_reg       <= HIGH_ALARM_RST;
            low_alarm_reg        <= LOW_ALARM_RST;
            cathode_polarity_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HIGH_ALARM:       high_alarm_reg       <= cfg_data;
                REG_LOW_ALARM:        low_alarm_reg        <= cfg_data;
                REG_CATHODE_POLARITY: cathode_polarity_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Stage 1: sign, magnitude and scaling by 5/8.
    logic                s1_valid_reg;
    logic                s1_neg_reg, s1_neg_next;
    logic [TENTHS_W-1:0] s1_tenths_reg, s1_tenths_next;
    logic [RAW_W-1:0]    mag;
    logic [RAW_W+2:0]    times5;

    always_comb
    begin
        s1_neg_next    = raw_reading[RAW_W-1];
        mag            = s1_neg_next ? (~raw_reading + RAW_W'(1)) : raw_reading;
        times5         = (RAW_W+3)'(mag) + (RAW_W+3)'({mag, 2'b0});
        s1_tenths_next = times5[3 +: TENTHS_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg    <= s1_neg_next;
        s1_tenths_reg <= s1_tenths_next;
    end

    // Stage 2: whole degrees, saturation and overflow.
    logic                s2_valid_reg;
    logic                s2_neg_reg;
    logic                s2_ovf_reg, s2_ovf_next;
    logic [SHOWN_W-1:0]  s2_shown_reg, s2_shown_next;
    logic [DEG_W-1:0]    s2_deg_reg, s2_deg_next;
    logic [TENTHS_W+15:0] deg_prod;

    always_comb
    begin
        deg_prod      = (TENTHS_W+16)'(s1_tenths_reg) * (TENTHS_W+16)'(RECIP_10_WIDE);
        s2_deg_next   = deg_prod[RECIP_10_WIDE_SH +: DEG_W];
        s2_ovf_next   = s1_tenths_reg > TENTHS_MAX;
        s2_shown_next = s2_ovf_next ? TENTHS_MAX[SHOWN_W-1:0]
                                    : s1_tenths_reg[SHOWN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_neg_reg   <= s1_neg_reg;
        s2_ovf_reg   <= s2_ovf_next;
        s2_shown_reg <= s2_shown_next;
        s2_deg_reg   <= s2_deg_next;
    end

    // Stage 3: alarm compare on signed degrees; digit split runs alongside.
    trdd_flags_t         s3_flags_reg, s3_flags_next;
    logic signed [SDEG_W-1:0] sdeg;
    logic signed [SDEG_W-1:0] high_lim, low_lim;

    always_comb
    begin
        sdeg     = s2_neg_reg ? -$signed({1'b0, s2_deg_reg}) : $signed({1'b0, s2_deg_reg});
        high_lim = SDEG_W'($signed(high_alarm_reg));
        low_lim  = SDEG_W'($signed(low_alarm_reg));
        s3_flags_next.is_negative = s2_neg_reg;
        s3_flags_next.overflow    = s2_ovf_reg;
        s3_flags_next.alarm       = (sdeg >= high_lim) || (sdeg < low_lim);
    end

    // Stage 4: flags wait for the second digit stage.
    trdd_flags_t s4_flags_reg;

    always_ff @(posedge clk)
    begin
        s3_flags_reg <= s3_flags_next;
        s4_flags_reg <= s3_flags_reg;
    end

    logic         dig_valid;
    trdd_digits_t dig;

    trdd_digits u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .shown     (s2_shown_reg),
        .out_valid (dig_valid),
        .digits    (dig)
    );

    // Stage 5: segment decoding into the output registers.
    logic               out_valid_reg;
    trdd_flags_t        out_flags_reg;
    trdd_digits_t       out_digits_reg;
    logic [SEG_W-1:0]   seg_th_reg, seg_hu_reg, seg_te_reg, seg_on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= dig_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flags_reg  <= s4_flags_reg;
        out_digits_reg <= dig;
        seg_th_reg     <= seg_code(dig.thousands, cathode_polarity_reg);
        seg_hu_reg     <= seg_code(dig.hundreds, cathode_polarity_reg);
        seg_te_reg     <= seg_code(dig.tens, cathode_polarity_reg);
        seg_on_reg     <= seg_code(dig.ones, cathode_polarity_reg);
    end

    assign result_valid       = out_valid_reg;
    assign is_negative        = out_flags_reg.is_negative;
    assign alarm              = out_flags_reg.alarm;
    assign overflow           = out_flags_reg.overflow;
    assign digit_thousands    = out_digits_reg.thousands;
    assign digit_hundreds     = out_digits_reg.hundreds;
    assign digit_tens         = out_digits_reg.tens;
    assign digit_ones         = out_digits_reg.ones;
    assign segments_thousands = seg_th_reg;
    assign segments_hundreds  = seg_hu_reg;
    assign segments_tens      = seg_te_reg;
    assign segments_ones      = seg_on_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for temp_reading_to_display_digits. Raw sensor words are
// sent as command beats with random gaps. A scoreboard predicts the sign,
// digits, segment codes, alarm and overflow of each beat from its own copy of
// the limit and polarity registers. It checks every result strobe against the
// oldest prediction. The run covers several register settings, including both
// limit extremes, crossed limits and both segment polarities.
// ----------------------------------------------------------------------------
module tb;
    import trdd_pkg::*;

    localparam int LATENCY        = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DISPLAY_MAX    = 9999;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 205;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Common-anode patterns of the digits 0 to 9.
    localparam logic [SEG_W-1:0] ANODE_SEGMENTS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // Hand-picked words: zero, smallest steps, half-degree rounding, alarm
    // thresholds at the reset limits, the saturation edge, the most positive
    // and most negative words, and alternating bit patterns.
    localparam logic [RAW_W-1:0] CORNER_WORDS [21] = '{
        16'h0000, 16'h0001, 16'h0008, 16'h000F, 16'hFFFF, 16'hFFF8, 16'hFFF0,
        16'h013F, 16'h0140, 16'h00CF, 16'h00D0, 16'h3E7F, 16'h3E80, 16'h7FFF,
        16'h8000, 16'h8001, 16'hFC90, 16'h07D0, 16'hC180, 16'hAAAA, 16'h5555
    };

    // One displayed reading, in the order of the result ports.
    typedef struct packed {
        logic               is_negative;
        logic [DIGIT_W-1:0] dig_thousands;
        logic [DIGIT_W-1:0] dig_hundreds;
        logic [DIGIT_W-1:0] dig_tens;
        logic [DIGIT_W-1:0] dig_ones;
        logic [SEG_W-1:0]   seg_thousands;
        logic [SEG_W-1:0]   seg_hundreds;
        logic [SEG_W-1:0]   seg_tens;
        logic [SEG_W-1:0]   seg_ones;
        logic               alarm;
        logic               overflow;
    } readout_t;

    // Predicts readouts and checks them in order of arrival.
    class display_scoreboard;
        logic [LIMIT_W-1:0] high_limit;
        logic [LIMIT_W-1:0] low_limit;
        logic               cathode;
        readout_t           expected_readouts[$];
        int                 mismatches;

        function new();
            high_limit = HIGH_ALARM_RST;
            low_limit  = LOW_ALARM_RST;
            cathode    = 1'b0;
            mismatches = 0;
        endfunction

        function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
            case (idx)
                REG_HIGH_ALARM:       high_limit = data;
                REG_LOW_ALARM:        low_limit  = data;
                REG_CATHODE_POLARITY: cathode    = data[0];
                default:              ;
            endcase
        endfunction

        function logic [SEG_W-1:0] segment_code(logic [DIGIT_W-1:0] digit);
            return cathode ? ~ANODE_SEGMENTS[digit] : ANODE_SEGMENTS[digit];
        endfunction

        function readout_t predict_readout(logic [RAW_W-1:0] raw);
            readout_t    r;
            logic [16:0] magnitude;
            int          tenths;
            int          shown;
            int          degrees;
            int          hi_deg;
            int          lo_deg;
            r.is_negative = raw[RAW_W-1];
            magnitude = r.is_negative ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
            // Scale 1/16 degree steps to tenths: times 5, then drop 3 bits.
            tenths = (int'(magnitude) * 5) >>> 3;
            r.overflow = tenths > DISPLAY_MAX;
            shown = r.overflow ? DISPLAY_MAX : tenths;
            // The alarm looks at the unsaturated whole degrees.
            degrees = r.is_negative ? -(tenths / 10) : tenths / 10;
            hi_deg = int'($signed(high_limit));
            lo_deg = int'($signed(low_limit));
            r.alarm = (degrees >= hi_deg) || (degrees < lo_deg);
            r.dig_thousands = DIGIT_W'(shown / 1000);
            r.dig_hundreds  = DIGIT_W'((shown % 1000) / 100);
            r.dig_tens      = DIGIT_W'((shown % 100) / 10);
            r.dig_ones      = DIGIT_W'(shown % 10);
            r.seg_thousands = segment_code(r.dig_thousands);
            r.seg_hundreds  = segment_code(r.dig_hundreds);
            r.seg_tens      = segment_code(r.dig_tens);
            r.seg_ones      = segment_code(r.dig_ones);
            return r;
        endfunction

        function void note_reading(logic [RAW_W-1:0] raw);
            expected_readouts.push_back(predict_readout(raw));
        endfunction

        function void compare_field(string label, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, label, want, got);
            end
        endfunction

        function void check_readout(readout_t got);
            readout_t want;
            if (expected_readouts.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_readouts.pop_front();
            compare_field("is_negative",        8'(want.is_negative),
                          8'(got.is_negative));
            compare_field("digit_thousands",    8'(want.dig_thousands),
                          8'(got.dig_thousands));
            compare_field("digit_hundreds",     8'(want.dig_hundreds),
                          8'(got.dig_hundreds));
            compare_field("digit_tens",         8'(want.dig_tens),
                          8'(got.dig_tens));
            compare_field("digit_ones",         8'(want.dig_ones),
                          8'(got.dig_ones));
            compare_field("segments_thousands", want.seg_thousands, got.seg_thousands);
            compare_field("segments_hundreds",  want.seg_hundreds,  got.seg_hundreds);
            compare_field("segments_tens",      want.seg_tens,      got.seg_tens);
            compare_field("segments_ones",      want.seg_ones,      got.seg_ones);
            compare_field("alarm",              8'(want.alarm),     8'(got.alarm));
            compare_field("overflow",           8'(want.overflow),  8'(got.overflow));
        endfunction

        function int pending();
            return expected_readouts.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [RAW_W-1:0]     raw_reading;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;
    logic                 result_valid;
    logic                 is_negative;
    logic [DIGIT_W-1:0]   digit_thousands;
    logic [DIGIT_W-1:0]   digit_hundreds;
    logic [DIGIT_W-1:0]   digit_tens;
    logic [DIGIT_W-1:0]   digit_ones;
    logic [SEG_W-1:0]     segments_thousands;
    logic [SEG_W-1:0]     segments_hundreds;
    logic [SEG_W-1:0]     segments_tens;
    logic [SEG_W-1:0]     segments_ones;
    logic                 alarm;
    logic                 overflow;
    readout_t             dut_readout;
    int                   idle_cycles = 0;

    display_scoreboard sb = new();

    temp_reading_to_display_digits u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .raw_reading        (raw_reading),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .result_valid       (result_valid),
        .is_negative        (is_negative),
        .digit_thousands    (digit_thousands),
        .digit_hundreds     (digit_hundreds),
        .digit_tens         (digit_tens),
        .digit_ones         (digit_ones),
        .segments_thousands (segments_thousands),
        .segments_hundreds  (segments_hundreds),
        .segments_tens      (segments_tens),
        .segments_ones      (segments_ones),
        .alarm              (alarm),
        .overflow           (overflow)
    );

    always #5 clk = ~clk;

    assign dut_readout = {is_negative, digit_thousands, digit_hundreds, digit_tens,
                          digit_ones, segments_thousands, segments_hundreds,
                          segments_tens, segments_ones, alarm, overflow};

    // Sample all handshakes at the rising edge, before any update lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_readout(dut_readout);
            if (start && !busy)
                sb.note_reading(raw_reading);
            if (cfg_valid && cfg_ready)
                sb.apply_cfg(cfg_index, cfg_data);
        end
    end

    // Watchdog: end the run if no beat of any kind moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Mostly back-to-back beats, some short gaps and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    // Readings: a share of raw noise, a share in the usual sensor range, and
    // the rest within three degrees of one of the alarm limits.
    function automatic logic [RAW_W-1:0] pick_reading(int hi_deg, int lo_deg);
        int r;
        int deg;
        r = $urandom_range(99);
        if (r < 30)
            return RAW_W'($urandom);
        if (r < 75)
            deg = int'($urandom_range(180)) - 55;
        else
            deg = (r < 88 ? hi_deg : lo_deg) + int'($urandom_range(4)) - 2;
        return RAW_W'(deg * 16 + int'($urandom_range(31)) - 16);
    endfunction

    task automatic send_reading(input logic [RAW_W-1:0] word, input int gap);
        start       <= 1'b1;
        raw_reading <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            start       <= 1'b0;
            raw_reading <= RAW_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every outstanding reading has come back.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Load all three registers while the pipeline is empty.
    task automatic load_settings(input int hi_deg, input int lo_deg,
                                 input logic [LIMIT_W-1:0] polarity_data,
                                 input bit poke_unused);
        settle();
        if (poke_unused)
            write_reg(REG_UNUSED, LIMIT_W'($urandom));
        write_reg(REG_HIGH_ALARM, LIMIT_W'(hi_deg));
        write_reg(REG_LOW_ALARM, LIMIT_W'(lo_deg));
        write_reg(REG_CATHODE_POLARITY, polarity_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int beats, input int hi_deg, input int lo_deg,
                             input bit burst);
        int gap;
        for (int i = 0; i < beats; i++)
        begin
            gap = burst ? 0 : pick_gap();
            send_reading(pick_reading(hi_deg, lo_deg), gap);
        end
    endtask

    initial
    begin
        int hi_deg;
        int lo_deg;
        logic [LIMIT_W-1:0] polarity_data;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        raw_reading <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_HIGH_ALARM;
        cfg_data    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner words under the reset register values.
        foreach (CORNER_WORDS[i])
            send_reading(CORNER_WORDS[i], (i % 4 == 3) ? 2 : 0);

        // Widest limits with cathode codes, then crossed extreme limits with
        // anode codes, then equal limits; the polarity data carries junk in
        // its upper bits, and an unused index is written too.
        load_settings(127, -128, 8'h01, 1'b0);
        run_phase(PHASE_BEATS, 127, -128, 1'b0);
        load_settings(-128, 127, 8'hFE, 1'b0);
        run_phase(PHASE_BEATS, -128, 127, 1'b1);
        load_settings(0, 0, 8'h03, 1'b1);
        run_phase(PHASE_BEATS, 0, 0, 1'b0);

        // Random limits, occasionally crossed, and random polarity.
        for (int p = 0; p < RANDOM_PHASES - 3; p++)
        begin
            hi_deg = int'($urandom_range(110)) - 30;
            lo_deg = hi_deg - int'($urandom_range(40));
            if ($urandom_range(4) == 0)
                lo_deg = hi_deg + int'($urandom_range(20, 1));
            if (lo_deg > 127)
                lo_deg = 127;
            polarity_data = LIMIT_W'($urandom);
            load_settings(hi_deg, lo_deg, polarity_data, p == 0);
            run_phase(PHASE_BEATS, hi_deg, lo_deg, p == 2);
        end

        settle();
        repeat (4 * LATENCY) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d readouts never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
